// ===== sv/pidc_pkg.sv =====
`default_nettype none

package pidc_pkg;

    // default data format, signed Q16.16
    localparam int PIDC_DATA_WIDTH    = 32;
    localparam int PIDC_FRACTION_BITS = 16;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int PERIOD_W    = 31;
    localparam int GAIN_W      = 32;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_TIME_STEP            = 3'd0,
        REG_TIME_STEP_RECIPROCAL = 3'd1,
        REG_PROPORTIONAL_GAIN    = 3'd2,
        REG_INTEGRAL_GAIN        = 3'd3,
        REG_DERIVATIVE_GAIN      = 3'd4
    } cfg_reg_t;

    // register reset values
    localparam logic [PERIOD_W-1:0]      RST_TIME_STEP            = 31'd6554;
    localparam logic [PERIOD_W-1:0]      RST_TIME_STEP_RECIPROCAL = 31'd655360;
    localparam logic signed [GAIN_W-1:0] RST_PROPORTIONAL_GAIN    = 32'sd58982;
    localparam logic signed [GAIN_W-1:0] RST_INTEGRAL_GAIN        = 32'sd328;
    localparam logic signed [GAIN_W-1:0] RST_DERIVATIVE_GAIN      = 32'sd0;

    // operand pair for the shared multiplier
    typedef enum logic [2:0] {
        MUL_ERR_DT,
        MUL_DIFF_RECIP,
        MUL_KP_ERR,
        MUL_KI_INTEG,
        MUL_KD_DERIV
    } mul_sel_t;

    // accumulator operation
    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } acc_op_t;

    // controller to datapath commands
    typedef struct packed {
        logic     load_err;
        logic     load_diff;
        logic     load_integ;
        logic     load_deriv;
        acc_op_t  acc_op;
        mul_sel_t mul_sel;
        logic     finish;
    } pidc_cmd_t;

endpackage

`default_nettype wire

// ===== sv/pidc_if.sv =====
`default_nettype none

// tick request channel: setpoint and measurement
interface pidc_in_if
    import pidc_pkg::*;
#(
    parameter int DATA_WIDTH = PIDC_DATA_WIDTH
) ();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] target_value;
    logic signed [DATA_WIDTH-1:0] measured_value;

    modport source (output valid, output target_value, output measured_value, input ready);
    modport sink   (input valid, input target_value, input measured_value, output ready);
endinterface

// result request channel: drive value and saturation flag
interface pidc_out_if
    import pidc_pkg::*;
#(
    parameter int DATA_WIDTH = PIDC_DATA_WIDTH
) ();
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] drive_value;
    logic                         saturated;

    modport source (output valid, output drive_value, output saturated, input ready);
    modport sink   (input valid, input drive_value, input saturated, output ready);
endinterface

// register write channel
interface pidc_cfg_if
    import pidc_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/pidc_ctrl.sv =====
`default_nettype none

module pidc_ctrl
    import pidc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  wire logic      out_ready,
    output pidc_cmd_t      cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_I,
        S_INTEG,
        S_DERIV,
        S_ACC_P,
        S_ACC_I,
        S_ACC_D,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;
    logic   slot_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    // command decode and next state
    always_comb
    begin
        cmd            = '0;
        cmd.acc_op     = ACC_HOLD;
        cmd.mul_sel    = MUL_ERR_DT;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load_err = accept;
                if (accept)
                begin
                    state_next = S_MUL_I;
                end
            end
            S_MUL_I:
            begin
                cmd.load_diff = 1'b1;
                cmd.mul_sel   = MUL_ERR_DT;
                state_next    = S_INTEG;
            end
            S_INTEG:
            begin
                cmd.load_integ = 1'b1;
                cmd.mul_sel    = MUL_DIFF_RECIP;
                state_next     = S_DERIV;
            end
            S_DERIV:
            begin
                cmd.load_deriv = 1'b1;
                cmd.mul_sel    = MUL_KP_ERR;
                state_next     = S_ACC_P;
            end
            S_ACC_P:
            begin
                cmd.acc_op  = ACC_LOAD;
                cmd.mul_sel = MUL_KI_INTEG;
                state_next  = S_ACC_I;
            end
            S_ACC_I:
            begin
                cmd.acc_op  = ACC_ADD;
                cmd.mul_sel = MUL_KD_DERIV;
                state_next  = S_ACC_D;
            end
            S_ACC_D:
            begin
                cmd.acc_op = ACC_ADD;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (slot_free)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // no second request taken while one is in flight
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("request accepted while previous one in flight");

    // fixed schedule from acceptance to the output state
    a_schedule: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##7 (state_reg == S_OUT))
        else $error("schedule slipped before output state");

    // result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || out_ready))
        else $error("result overwritten while stalled");

    // a result appears only from the output state
    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result valid raised outside output state");

endmodule

`default_nettype wire

// ===== sv/pidc_datapath.sv =====
`default_nettype none

module pidc_datapath
    import pidc_pkg::*;
#(
    parameter int DATA_WIDTH    = PIDC_DATA_WIDTH,
    parameter int FRACTION_BITS = PIDC_FRACTION_BITS
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire pidc_cmd_t                    cmd,
    input  wire logic signed [DATA_WIDTH-1:0] target_value,
    input  wire logic signed [DATA_WIDTH-1:0] measured_value,
    pidc_cfg_if.sink                          cfg,
    output logic signed [DATA_WIDTH-1:0]      drive_value,
    output logic                              saturated
);

    localparam int AW    = DATA_WIDTH + 1;
    localparam int BW    = GAIN_W + 1;
    localparam int PW    = AW + BW;
    localparam int ACC_W = PW + 2;

    localparam logic [DATA_WIDTH-1:0] VAL_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [DATA_WIDTH-1:0] VAL_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};

    // clamp to the data range, top bit flags a clip
    function automatic logic [DATA_WIDTH:0] sat_dw(input logic signed [ACC_W-1:0] x);
        logic top_ones;
        logic top_zeros;
        top_ones  = &x[ACC_W-1:DATA_WIDTH-1];
        top_zeros = ~(|x[ACC_W-1:DATA_WIDTH-1]);
        if (top_ones || top_zeros)
            sat_dw = {1'b0, x[DATA_WIDTH-1:0]};
        else if (x[ACC_W-1])
            sat_dw = {1'b1, VAL_MIN};
        else
            sat_dw = {1'b1, VAL_MAX};
    endfunction

    // configuration registers
    logic [PERIOD_W-1:0]      dt_reg;
    logic [PERIOD_W-1:0]      recip_reg;
    logic signed [GAIN_W-1:0] kp_reg;
    logic signed [GAIN_W-1:0] ki_reg;
    logic signed [GAIN_W-1:0] kd_reg;

    // controller state
    logic signed [DATA_WIDTH-1:0] integ_reg;
    logic signed [DATA_WIDTH-1:0] prev_reg;

    // working registers
    logic signed [DATA_WIDTH-1:0] err_reg;
    logic signed [AW-1:0]         diff_reg;
    logic signed [DATA_WIDTH-1:0] deriv_reg;
    logic signed [PW-1:0]         prod_reg;
    logic signed [ACC_W-1:0]      acc_reg;
    logic                         integ_clip_reg;
    logic signed [DATA_WIDTH-1:0] drive_reg;
    logic                         sat_reg;

    logic signed [AW-1:0]         err_diff;
    logic [DATA_WIDTH:0]          err_sat;
    logic signed [AW-1:0]         mul_a;
    logic signed [BW-1:0]         mul_b;
    logic signed [PW-1:0]         prod_sh;
    logic signed [ACC_W-1:0]      prod_ext;
    logic signed [ACC_W-1:0]      integ_sum;
    logic [DATA_WIDTH:0]          integ_sat;
    logic [DATA_WIDTH:0]          deriv_sat;
    logic signed [ACC_W-1:0]      acc_sh;
    logic [DATA_WIDTH:0]          drive_sat;

    assign cfg.ready = 1'b1;

    // register writes, unknown indexes dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dt_reg    <= RST_TIME_STEP;
            recip_reg <= RST_TIME_STEP_RECIPROCAL;
            kp_reg    <= RST_PROPORTIONAL_GAIN;
            ki_reg    <= RST_INTEGRAL_GAIN;
            kd_reg    <= RST_DERIVATIVE_GAIN;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_TIME_STEP:            dt_reg    <= cfg.data[PERIOD_W-1:0];
                REG_TIME_STEP_RECIPROCAL: recip_reg <= cfg.data[PERIOD_W-1:0];
                REG_PROPORTIONAL_GAIN:    kp_reg    <= cfg.data[GAIN_W-1:0];
                REG_INTEGRAL_GAIN:        ki_reg    <= cfg.data[GAIN_W-1:0];
                REG_DERIVATIVE_GAIN:      kd_reg    <= cfg.data[GAIN_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // error straight from the request
    assign err_diff = $signed({target_value[DATA_WIDTH-1], target_value})
                    - $signed({measured_value[DATA_WIDTH-1], measured_value});
    assign err_sat  = sat_dw({{(ACC_W-AW){err_diff[AW-1]}}, err_diff});

    // shared multiplier operand select
    always_comb
    begin
        mul_a = {err_reg[DATA_WIDTH-1], err_reg};
        mul_b = {2'b00, dt_reg};
        unique case (cmd.mul_sel)
            MUL_ERR_DT:
            begin
                mul_a = {err_reg[DATA_WIDTH-1], err_reg};
                mul_b = {2'b00, dt_reg};
            end
            MUL_DIFF_RECIP:
            begin
                mul_a = diff_reg;
                mul_b = {2'b00, recip_reg};
            end
            MUL_KP_ERR:
            begin
                mul_a = {err_reg[DATA_WIDTH-1], err_reg};
                mul_b = {kp_reg[GAIN_W-1], kp_reg};
            end
            MUL_KI_INTEG:
            begin
                mul_a = {integ_reg[DATA_WIDTH-1], integ_reg};
                mul_b = {ki_reg[GAIN_W-1], ki_reg};
            end
            MUL_KD_DERIV:
            begin
                mul_a = {deriv_reg[DATA_WIDTH-1], deriv_reg};
                mul_b = {kd_reg[GAIN_W-1], kd_reg};
            end
            default:
            begin
            end
        endcase
    end

    // floored product, integral and derivative clamps
    assign prod_sh   = prod_reg >>> FRACTION_BITS;
    assign prod_ext  = {{(ACC_W-PW){prod_reg[PW-1]}}, prod_reg};
    assign integ_sum = {{(ACC_W-PW){prod_sh[PW-1]}}, prod_sh}
                     + {{(ACC_W-DATA_WIDTH){integ_reg[DATA_WIDTH-1]}}, integ_reg};
    assign integ_sat = sat_dw(integ_sum);
    assign deriv_sat = sat_dw({{(ACC_W-PW){prod_sh[PW-1]}}, prod_sh});
    assign acc_sh    = acc_reg >>> FRACTION_BITS;
    assign drive_sat = sat_dw(acc_sh);

    // integral and previous error
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg <= '0;
            prev_reg  <= '0;
        end
        else
        begin
            if (cmd.load_integ)
                integ_reg <= integ_sat[DATA_WIDTH-1:0];
            if (cmd.finish)
                prev_reg <= err_reg;
        end
    end

    // working registers and result payload
    always_ff @(posedge clk)
    begin
        prod_reg <= PW'(mul_a) * PW'(mul_b);
        if (cmd.load_err)
            err_reg <= err_sat[DATA_WIDTH-1:0];
        if (cmd.load_diff)
            diff_reg <= $signed({err_reg[DATA_WIDTH-1], err_reg})
                      - $signed({prev_reg[DATA_WIDTH-1], prev_reg});
        if (cmd.load_integ)
            integ_clip_reg <= integ_sat[DATA_WIDTH];
        if (cmd.load_deriv)
            deriv_reg <= deriv_sat[DATA_WIDTH-1:0];
        unique case (cmd.acc_op)
            ACC_LOAD: acc_reg <= prod_ext;
            ACC_ADD:  acc_reg <= acc_reg + prod_ext;
            default:
            begin
            end
        endcase
        if (cmd.finish)
        begin
            drive_reg <= drive_sat[DATA_WIDTH-1:0];
            sat_reg   <= drive_sat[DATA_WIDTH] | integ_clip_reg;
        end
    end

    assign drive_value = drive_reg;
    assign saturated   = sat_reg;

endmodule

`default_nettype wire

// ===== sv/pid_controller_step_unit.sv =====
// Discrete PID controller step unit.
// One request on the tick channel carries a setpoint and a measurement in
// signed fixed point (DATA_WIDTH bits, FRACTION_BITS fraction bits). Each
// request yields exactly one result on the result channel: the drive value
// and a flag that is set when the integral or the output was clipped.
// Gains and the sample period are written on the cfg channel, which is
// always ready; write them only while no request is in flight.
// A request is taken only while the unit is idle; it then runs through the
// states MUL_I, INTEG, DERIV, ACC_P, ACC_I, ACC_D and OUT before its result
// is loaded into the output register, and only then is a new request taken.
// The single shared multiplier handles the five products of a tick in turn.
// The output register holds one result; while the receiver stalls, the
// unit finishes the next tick and then waits until that register is free.
// Tick ready is high only while the unit is idle.
// Reset clears the stored integral and previous error, restores the
// register defaults and empties the output register.
`default_nettype none

module pid_controller_step_unit
    import pidc_pkg::*;
#(
    parameter int DATA_WIDTH    = PIDC_DATA_WIDTH,
    parameter int FRACTION_BITS = PIDC_FRACTION_BITS
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    pidc_in_if.sink    tick,
    pidc_out_if.source result,
    pidc_cfg_if.sink   cfg
);

    pidc_cmd_t cmd;
    logic      in_ready;
    logic      out_valid;

    assign tick.ready   = in_ready;
    assign result.valid = out_valid;

    // sequencer
    pidc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (tick.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (result.ready),
        .cmd       (cmd)
    );

    // arithmetic and registers
    pidc_datapath #(
        .DATA_WIDTH    (DATA_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .target_value   (tick.target_value),
        .measured_value (tick.measured_value),
        .cfg            (cfg),
        .drive_value    (result.drive_value),
        .saturated      (result.saturated)
    );

endmodule

`default_nettype wire
